// File: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clocked properties with and without reset gating
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define PPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pps assertion failed");

// property checked on every edge, reset included
`define PPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pps assertion failed");

`endif

// File: sv/pps_pkg.sv
// shared types, constants and tables of the pure pursuit steering block
// used by the cordic unit, datapath, controller, top level and checker
package pps_pkg;

    // cordic datapath widths
    localparam int unsigned CW      = 38;
    localparam int unsigned ZW      = 22;
    localparam int unsigned MAG_W   = 36;
    localparam int unsigned HALF_W  = MAG_W / 2;
    localparam int unsigned KINV_W  = 30;
    localparam int unsigned PROD_W  = HALF_W + KINV_W;
    localparam int unsigned ACC_W   = MAG_W + KINV_W;
    localparam int unsigned ATAN_IW = 5;
    localparam int unsigned SIN_W   = 32;
    localparam int unsigned NUM_W   = 24;
    localparam int unsigned WP_W    = 55;
    localparam int unsigned STEER_W = 15;

    // config register widths and reset values
    localparam int unsigned LA_W = 23;
    localparam int unsigned WB_W = 20;
    localparam logic [LA_W-1:0] LA_RESET = 23'd327680;
    localparam logic [WB_W-1:0] WB_RESET = 20'd183501;
    localparam logic REG_LOOKAHEAD  = 1'b0;
    localparam logic REG_WHEEL_BASE = 1'b1;

    // fixed point constants
    localparam logic [KINV_W-1:0]    KINV_Q30    = 30'd652032874;
    localparam logic [ACC_W-1:0]     ROUND_Q30   = ACC_W'(64'd1 << 29);
    localparam logic signed [ZW-1:0] PI_Q16      = 22'sd205887;
    localparam logic signed [ZW-1:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [ZW-1:0] STEER_RND   = 22'sd4;
    localparam logic signed [ZW-1:0] STEER_LIM   = 22'sd12868;
    localparam int                   STEER_LIMIT = 12868;
    localparam int unsigned          MIN_POINTS  = 3;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    // cordic operand source
    typedef enum logic [1:0] {
        SRC_EGO   = 2'd0,
        SRC_PREV  = 2'd1,
        SRC_STEER = 2'd2
    } t_csrc;

    typedef enum logic [1:0] {
        C_IDLE, C_ITER, C_MUL_LO, C_MUL_HI
    } t_cstate;

    typedef enum logic [4:0] {
        S_IDLE, S_QCHK,
        S_N_RD, S_N_GO, S_N_WAIT,
        S_S_RD0, S_S_PREV, S_S_RD, S_S_GO, S_S_WAIT,
        S_G_RD, S_G_GO, S_G_WAIT,
        S_WRAP, S_FOLD, S_SIN_GO, S_SIN_WAIT, S_NUM,
        S_AT_GO, S_AT_WAIT, S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic  take;
        logic  set_few;
        logic  idx_zero;
        logic  idx_inc;
        logic  idx_best;
        logic  idx_last;
        logic  cordic_start;
        logic  cordic_rot;
        t_csrc src;
        logic  near_upd;
        logic  prev_load;
        logic  sum_clear;
        logic  seg_acc;
        logic  dist_load;
        logic  wrap_step;
        logic  fold;
        logic  sin_load;
        logic  num_load;
        logic  steer_load;
        logic  out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic few;
        logic done;
        logic last;
        logic seg_over;
        logic no_seg;
        logic wrap_need;
        logic out_busy;
    } t_stat;

    // arctangent table, q16 radians
    function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IW-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = 22'sd51472;
            5'd1:    v = 22'sd30386;
            5'd2:    v = 22'sd16055;
            5'd3:    v = 22'sd8150;
            5'd4:    v = 22'sd4091;
            5'd5:    v = 22'sd2047;
            5'd6:    v = 22'sd1024;
            5'd7:    v = 22'sd512;
            5'd8:    v = 22'sd256;
            5'd9:    v = 22'sd128;
            5'd10:   v = 22'sd64;
            5'd11:   v = 22'sd32;
            5'd12:   v = 22'sd16;
            5'd13:   v = 22'sd8;
            5'd14:   v = 22'sd4;
            5'd15:   v = 22'sd2;
            5'd16:   v = 22'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/pps_cordic.sv
// iterative cordic: vectoring (angle and gain-corrected magnitude) or rotation (sin)
// depends on pps_pkg for widths, constants and the arctangent table
module pps_cordic import pps_pkg::*; #(
    parameter int unsigned ITERS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_rotate,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_done,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [MAG_W-1:0]     o_mag
);

    localparam int unsigned IW = $clog2(ITERS);

    t_cstate              r_state, n_state;
    logic [IW-1:0]        r_iter, n_iter;
    logic                 r_rot, n_rot;
    logic                 r_done, n_done;
    logic signed [CW-1:0] r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [PROD_W-1:0]    r_p, n_p;
    logic [MAG_W-1:0]     r_mag, n_mag;

    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 plus;
    logic [CW-1:0]        x_pos;
    logic [MAG_W-1:0]     x_u;
    logic [PROD_W-1:0]    prod;
    logic [ACC_W-1:0]     acc;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_iter <= n_iter;
        r_rot  <= n_rot;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_p    <= n_p;
        r_mag  <= n_mag;
    end

    // one micro-rotation per cycle, then in vectoring mode a two-step gain multiply
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_rot   = r_rot;
        n_done  = 1'b0;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_p     = r_p;
        n_mag   = r_mag;
        xs      = r_x >>> r_iter;
        ys      = r_y >>> r_iter;
        at      = atan_q16(ATAN_IW'(r_iter));
        plus    = r_rot ? r_z[ZW-1] : (!r_y[CW-1] && (r_y != '0));
        x_pos   = r_x[CW-1] ? '0 : r_x;
        x_u     = x_pos[MAG_W-1:0];
        prod    = '0;
        acc     = '0;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_rot  = i_rotate;
                    n_iter = '0;
                    n_state = C_ITER;
                    if (i_rotate) begin
                        n_x = CW'(KINV_Q30);
                        n_y = '0;
                        n_z = i_z;
                    end else if ((i_x == '0) && (i_y == '0)) begin
                        // zero vector: angle and magnitude zero
                        n_x = '0;
                        n_y = '0;
                        n_z = '0;
                        n_state = C_MUL_LO;
                    end else if (i_x[CW-1]) begin
                        n_x = -i_x;
                        n_y = -i_y;
                        n_z = i_y[CW-1] ? -PI_Q16 : PI_Q16;
                    end else begin
                        n_x = i_x;
                        n_y = i_y;
                        n_z = '0;
                    end
                end
            end
            C_ITER: begin
                if (plus) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + at;
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - at;
                end
                if (r_iter == IW'(ITERS - 1)) begin
                    if (r_rot) begin
                        n_done  = 1'b1;
                        n_state = C_IDLE;
                    end else begin
                        n_state = C_MUL_LO;
                    end
                end else begin
                    n_iter = r_iter + IW'(1);
                end
            end
            C_MUL_LO: begin
                prod    = PROD_W'(x_u[HALF_W-1:0]) * PROD_W'(KINV_Q30);
                n_p     = prod;
                n_state = C_MUL_HI;
            end
            C_MUL_HI: begin
                prod    = PROD_W'(x_u[MAG_W-1:HALF_W]) * PROD_W'(KINV_Q30);
                acc     = ACC_W'(r_p) + {prod, {HALF_W{1'b0}}} + ROUND_Q30;
                n_mag   = acc[ACC_W-1:KINV_W];
                n_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_mag  = r_mag;

endmodule

// File: sv/pps_dp.sv
// datapath: point store, query registers, cordic unit and result register
// depends on pps_pkg and pps_cordic; driven by pps_ctrl commands
module pps_dp import pps_pkg::*; #(
    parameter int unsigned MAX_POINTS = 256,
    parameter int unsigned ITERS      = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  logic [1:0]                i_action,
    input  logic signed [31:0]        i_point_x,
    input  logic signed [31:0]        i_point_y,
    input  logic signed [31:0]        i_ego_x,
    input  logic signed [31:0]        i_ego_y,
    input  logic signed [15:0]        i_ego_heading,
    input  logic [LA_W-1:0]           i_lookahead,
    input  logic [WB_W-1:0]           i_wheel_base,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [STEER_W-1:0] o_steer_angle,
    output logic                      o_too_few_points,
    output logic                      o_points_dropped
);

    localparam int unsigned AW    = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned SUM_W = MAG_W + AW + 1;

    // point store
    logic [31:0] r_mem_x [MAX_POINTS];
    logic [31:0] r_mem_y [MAX_POINTS];

    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic                      r_out_valid;
    logic signed [STEER_W-1:0] r_out_steer;
    logic                      r_out_few, r_out_drop;

    logic signed [31:0]        r_ex, r_ey, r_rdx, r_rdy, r_prevx, r_prevy;
    logic signed [15:0]        r_head;
    logic [CNT_W-1:0]          r_idx, r_best_idx;
    logic [MAG_W-1:0]          r_best_mag, r_dist;
    logic [SUM_W-1:0]          r_sum;
    logic signed [ZW-1:0]      r_alpha;
    logic signed [SIN_W-1:0]   r_sin;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [STEER_W-1:0] r_steer;
    logic                      r_few;

    logic                      append;
    logic                      near_take;
    logic signed [CW-1:0]      c_x, c_y;
    logic                      c_done;
    logic signed [CW-1:0]      c_y_out;
    logic signed [ZW-1:0]      c_z;
    logic [MAG_W-1:0]          c_mag;
    logic [SUM_W-1:0]          sum_next;
    logic signed [WP_W-1:0]    wprod, wrnd;
    logic signed [ZW-1:0]      st;

    assign append = i_cmd.take && (i_action == ACT_APPEND)
                    && (r_count < CNT_W'(MAX_POINTS));

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (append) begin
            r_mem_x[r_count[AW-1:0]] <= i_point_x;
            r_mem_y[r_count[AW-1:0]] <= i_point_y;
        end
        r_rdx <= r_mem_x[r_idx[AW-1:0]];
        r_rdy <= r_mem_y[r_idx[AW-1:0]];
    end

    // fill count, overflow flag and result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take && (i_action == ACT_CLEAR)) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.take && (i_action == ACT_APPEND)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cordic operand select
    always_comb begin
        unique case (i_cmd.src)
            SRC_EGO: begin
                c_x = CW'(r_rdx) - CW'(r_ex);
                c_y = CW'(r_rdy) - CW'(r_ey);
            end
            SRC_PREV: begin
                c_x = CW'(r_rdx) - CW'(r_prevx);
                c_y = CW'(r_rdy) - CW'(r_prevy);
            end
            SRC_STEER: begin
                c_x = CW'(r_dist);
                c_y = CW'(r_num);
            end
            default: begin
                c_x = '0;
                c_y = '0;
            end
        endcase
    end

    pps_cordic #(
        .ITERS (ITERS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.cordic_start),
        .i_rotate (i_cmd.cordic_rot),
        .i_x      (c_x),
        .i_y      (c_y),
        .i_z      (r_alpha),
        .o_done   (c_done),
        .o_y      (c_y_out),
        .o_z      (c_z),
        .o_mag    (c_mag)
    );

    // arithmetic feeding the query registers
    assign sum_next = r_sum + SUM_W'(c_mag);
    assign wprod    = $signed({1'b0, i_wheel_base}) * r_sin;
    assign wrnd     = (wprod <<< 1) + $signed(WP_W'(ROUND_Q30));
    assign st       = (c_z + STEER_RND) >>> 3;

    // current point becomes the nearest one
    assign near_take = i_cmd.near_upd && ((r_idx == '0) || (c_mag < r_best_mag));

    // query registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ex   <= i_ego_x;
            r_ey   <= i_ego_y;
            r_head <= i_ego_heading;
        end
        // walk index
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end else if (i_cmd.idx_best) begin
            r_idx <= near_take ? r_idx : r_best_idx;
        end else if (i_cmd.idx_last) begin
            r_idx <= r_count - CNT_W'(1);
        end
        // nearest point, first one wins ties
        if (near_take) begin
            r_best_mag <= c_mag;
            r_best_idx <= r_idx;
        end
        if (i_cmd.prev_load) begin
            r_prevx <= r_rdx;
            r_prevy <= r_rdy;
        end
        if (i_cmd.sum_clear) begin
            r_sum <= '0;
        end else if (i_cmd.seg_acc) begin
            r_sum <= sum_next;
        end
        // goal distance and steering angle error
        if (i_cmd.dist_load) begin
            r_dist  <= c_mag;
            r_alpha <= c_z - (ZW'(r_head) <<< 3);
        end else if (i_cmd.wrap_step) begin
            r_alpha <= (r_alpha > PI_Q16) ? r_alpha - TWO_PI_Q16 : r_alpha + TWO_PI_Q16;
        end else if (i_cmd.fold) begin
            if (r_alpha > HALF_PI_Q16) begin
                r_alpha <= PI_Q16 - r_alpha;
            end else if (r_alpha < -HALF_PI_Q16) begin
                r_alpha <= -PI_Q16 - r_alpha;
            end
        end
        if (i_cmd.sin_load) begin
            r_sin <= SIN_W'(c_y_out);
        end
        if (i_cmd.num_load) begin
            r_num <= NUM_W'(wrnd >>> 30);
        end
        // final angle, rounded to q13 and clamped
        if (i_cmd.set_few) begin
            r_steer <= '0;
            r_few   <= 1'b1;
        end else if (i_cmd.steer_load) begin
            r_few <= 1'b0;
            if (st > STEER_LIM) begin
                r_steer <= STEER_W'(STEER_LIM);
            end else if (st < -STEER_LIM) begin
                r_steer <= STEER_W'(-STEER_LIM);
            end else begin
                r_steer <= STEER_W'(st);
            end
        end
        if (i_cmd.out_load) begin
            r_out_steer <= r_steer;
            r_out_few   <= r_few;
            r_out_drop  <= r_ovf;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.few       = r_count < CNT_W'(MIN_POINTS);
        o_stat.done      = c_done;
        o_stat.last      = r_idx == (r_count - CNT_W'(1));
        o_stat.seg_over  = sum_next > SUM_W'(i_lookahead);
        o_stat.no_seg    = ((CNT_W + 1)'(r_best_idx) + (CNT_W + 1)'(1))
                           >= (CNT_W + 1)'(r_count);
        o_stat.wrap_need = (r_alpha > PI_Q16) || (r_alpha < -PI_Q16);
        o_stat.out_busy  = r_out_valid;
    end

    assign o_valid          = r_out_valid;
    assign o_steer_angle    = r_out_steer;
    assign o_too_few_points = r_out_few;
    assign o_points_dropped = r_out_drop;

endmodule

// File: sv/pps_ctrl.sv
// controller: sequences append, clear and the steps of a steering query
// depends on pps_pkg for the state, command and status types
module pps_ctrl import pps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    input  t_stat      i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.src = SRC_EGO;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_action == ACT_QUERY) begin
                        n_state = S_QCHK;
                    end
                end
            end
            S_QCHK: begin
                if (i_stat.few) begin
                    o_cmd.set_few = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.idx_zero = 1'b1;
                    n_state = S_N_RD;
                end
            end
            // nearest point search
            S_N_RD: n_state = S_N_GO;
            S_N_GO: begin
                o_cmd.cordic_start = 1'b1;
                o_cmd.src = SRC_EGO;
                n_state = S_N_WAIT;
            end
            S_N_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.near_upd = 1'b1;
                    if (i_stat.last) begin
                        o_cmd.sum_clear = 1'b1;
                        o_cmd.idx_best  = 1'b1;
                        n_state = S_S_RD0;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_N_RD;
                    end
                end
            end
            // arc length walk from the nearest point
            S_S_RD0: n_state = S_S_PREV;
            S_S_PREV: begin
                o_cmd.prev_load = 1'b1;
                if (i_stat.no_seg) begin
                    o_cmd.idx_last = 1'b1;
                    n_state = S_G_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_S_RD;
                end
            end
            S_S_RD: n_state = S_S_GO;
            S_S_GO: begin
                o_cmd.cordic_start = 1'b1;
                o_cmd.src = SRC_PREV;
                o_cmd.prev_load = 1'b1;
                n_state = S_S_WAIT;
            end
            S_S_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.seg_acc = 1'b1;
                    priority if (i_stat.seg_over || i_stat.last) begin
                        n_state = S_G_RD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_S_RD;
                    end
                end
            end
            // goal point bearing and distance
            S_G_RD: n_state = S_G_GO;
            S_G_GO: begin
                o_cmd.cordic_start = 1'b1;
                o_cmd.src = SRC_EGO;
                n_state = S_G_WAIT;
            end
            S_G_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.dist_load = 1'b1;
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (i_stat.wrap_need) begin
                    o_cmd.wrap_step = 1'b1;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state = S_SIN_GO;
            end
            S_SIN_GO: begin
                o_cmd.cordic_start = 1'b1;
                o_cmd.cordic_rot = 1'b1;
                n_state = S_SIN_WAIT;
            end
            S_SIN_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.sin_load = 1'b1;
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                o_cmd.num_load = 1'b1;
                n_state = S_AT_GO;
            end
            S_AT_GO: begin
                o_cmd.cordic_start = 1'b1;
                o_cmd.src = SRC_STEER;
                n_state = S_AT_WAIT;
            end
            S_AT_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.steer_load = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sv/pure_pursuit_steering.sv
// Pure pursuit steering. A query with at least three stored points runs one shared
// iterative cordic unit; a point vector takes a store read, a start, the
// micro-rotations, the gain multiply and the done handshake. A query with fewer
// points skips the cordic unit. The result waits in an output register, so a new
// request is taken while it is still pending. No clearing pass is needed after reset.
// depends on pps_pkg, pps_ctrl, pps_dp and pps_cordic
module pure_pursuit_steering import pps_pkg::*; #(
    parameter int unsigned MAX_POINTS        = 256,
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream: request
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, ego_x, ego_y, ego_heading
    input  logic [143:0] s_axis_tdata,
    // action
    input  logic [1:0]   s_axis_tuser,
    // master stream: result
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // steer_angle, zero pad
    output logic [15:0]  m_axis_tdata,
    // too_few_points, points_dropped
    output logic [1:0]   m_axis_tuser,
    // config port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [LA_W-1:0]           r_lookahead;
    logic [WB_W-1:0]           r_wheel_base;
    t_cmd                      cmd;
    t_stat                     stat;
    logic signed [STEER_W-1:0] steer;

    // config registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead  <= LA_RESET;
            r_wheel_base <= WB_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_WHEEL_BASE) begin
                r_wheel_base <= pwdata[WB_W-1:0];
            end else begin
                r_lookahead <= pwdata[LA_W-1:0];
            end
        end
    end

    // config readback
    always_comb begin
        if (paddr[2] == REG_LOOKAHEAD) begin
            prdata = 32'(r_lookahead);
        end else begin
            prdata = 32'(r_wheel_base);
        end
    end

    pps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .i_stat   (stat),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    pps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .ITERS      (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (s_axis_tuser),
        .i_point_x        (s_axis_tdata[31:0]),
        .i_point_y        (s_axis_tdata[63:32]),
        .i_ego_x          (s_axis_tdata[95:64]),
        .i_ego_y          (s_axis_tdata[127:96]),
        .i_ego_heading    (s_axis_tdata[143:128]),
        .i_lookahead      (r_lookahead),
        .i_wheel_base     (r_wheel_base),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_steer_angle    (steer),
        .o_too_few_points (m_axis_tuser[0]),
        .o_points_dropped (m_axis_tuser[1])
    );

    assign m_axis_tdata = {1'b0, steer};

endmodule

// File: sv/pps_checker.sv
// port-level checker for pure_pursuit_steering, bound to the top level
// depends on pps_pkg and assert_macros.svh
`include "assert_macros.svh"

module pps_checker import pps_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    `PPS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // too few points gives a zero angle
    `PPS_ASSERT(a_few_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)

    // angle stays within the steering limit
    `PPS_ASSERT(a_clamp, i_clk, i_rst_n, m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= STEER_LIMIT) && ($signed(m_axis_tdata[14:0]) >= -STEER_LIMIT) && !m_axis_tdata[15])

    // reset empties the result register
    `PPS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready)

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (.*);

// File: tb/sv/tb_pure_pursuit_steering.sv
// self-checking testbench for the pure pursuit steering block
// depends on pps_pkg and pure_pursuit_steering; a class predicts each query result
module tb_pure_pursuit_steering;
    import pps_pkg::*;

    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned ROT_STEPS   = 16;
    localparam int          STALL_LIMIT = 100000;
    localparam int          HOLD_CYCLES = 3000;
    localparam logic [2:0]  ADDR_LA     = {REG_LOOKAHEAD, 2'b00};
    localparam logic [2:0]  ADDR_WB     = {REG_WHEEL_BASE, 2'b00};

    typedef struct {
        logic signed [14:0] steer;
        bit                 few;
        bit                 dropped;
    } t_steer_res;

    // steering predictor and store of pending answers
    class steer_scoreboard;
        longint            px[STORE_DEPTH];
        longint            py[STORE_DEPTH];
        int unsigned       npts;
        bit                ovf;
        longint unsigned   look;
        longint unsigned   wbase;
        t_steer_res        answers[$];
        int                errors;
        int                matched;
        longint            arctan[ROT_STEPS];

        function new();
            arctan = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2};
            npts  = 0;
            ovf   = 0;
            look  = 327680;
            wbase = 183501;
            errors  = 0;
            matched = 0;
        endfunction

        function void set_reg(bit idx, longint unsigned v);
            if (idx == REG_LOOKAHEAD) look = v & ((64'd1 << LA_W) - 1);
            else wbase = v & ((64'd1 << WB_W) - 1);
        endfunction

        // vectoring rotation: bearing in q16 and gain corrected length
        function longint unsigned polar(longint x, longint y, output longint ang);
            longint z;
            longint xs;
            longint ys;
            longint unsigned prod;
            z = 0;
            if (x == 0 && y == 0) begin
                ang = 0;
                return 0;
            end
            if (x < 0) begin
                z = (y >= 0) ? 205887 : -205887;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + arctan[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - arctan[i];
                end
            end
            ang = z;
            if (x < 0) x = 0;
            prod = longint'(x) * 64'd652032874 + (64'd1 << 29);
            return prod >> 30;
        endfunction

        // rotation mode sine, q30 out
        function longint sine_q30(longint a);
            longint x;
            longint y;
            longint xs;
            longint ys;
            x = 652032874;
            y = 0;
            while (a > 205887) a = a - 411775;
            while (a < -205887) a = a + 411775;
            if (a > 102944) a = 205887 - a;
            else if (a < -102944) a = -205887 - a;
            for (int i = 0; i < ROT_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (a >= 0) begin
                    x = x - ys; y = y + xs; a = a - arctan[i];
                end else begin
                    x = x + ys; y = y - xs; a = a + arctan[i];
                end
            end
            return y;
        endfunction

        // update state for one accepted request, queue the answer of a query
        function void note_request(logic [1:0] act, logic [143:0] d);
            t_steer_res r;
            longint ex, ey, hd, ang, bearing, num, st;
            longint unsigned best_d, dd, sum, goal_len;
            int unsigned best, goal;
            if (act == ACT_APPEND) begin
                if (npts < STORE_DEPTH) begin
                    px[npts] = longint'($signed(d[31:0]));
                    py[npts] = longint'($signed(d[63:32]));
                    npts++;
                end else begin
                    ovf = 1;
                end
                return;
            end
            if (act == ACT_CLEAR) begin
                npts = 0;
                ovf  = 0;
                return;
            end
            if (act != ACT_QUERY) return;
            r.dropped = ovf;
            if (npts < MIN_POINTS) begin
                r.steer = 0;
                r.few   = 1;
                answers.push_back(r);
                return;
            end
            ex = longint'($signed(d[95:64]));
            ey = longint'($signed(d[127:96]));
            hd = longint'($signed(d[143:128]));
            // nearest point, earliest wins a tie
            best   = 0;
            best_d = polar(px[0] - ex, py[0] - ey, ang);
            for (int unsigned i = 1; i < npts; i++) begin
                dd = polar(px[i] - ex, py[i] - ey, ang);
                if (dd < best_d) begin
                    best_d = dd;
                    best   = i;
                end
            end
            // walk forward until the arc passes the lookahead
            goal = npts - 1;
            sum  = 0;
            for (int unsigned i = best + 1; i < npts; i++) begin
                sum = sum + polar(px[i] - px[i-1], py[i] - py[i-1], ang);
                if (sum > look) begin
                    goal = i;
                    break;
                end
            end
            goal_len = polar(px[goal] - ex, py[goal] - ey, bearing);
            num  = 2 * longint'(wbase) * sine_q30(bearing - hd * 8);
            num  = (num + (64'sd1 <<< 29)) >>> 30;
            void'(polar(longint'(goal_len), num, ang));
            st = (ang + 4) >>> 3;
            if (st > STEER_LIMIT) st = STEER_LIMIT;
            if (st < -STEER_LIMIT) st = -STEER_LIMIT;
            r.steer = st[14:0];
            r.few   = 0;
            answers.push_back(r);
        endfunction

        function void check_result(logic [15:0] td, logic [1:0] tu);
            t_steer_res e;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result steer=%0d flags=%b", $time,
                         $signed(td[14:0]), tu);
                errors++;
                return;
            end
            e = answers.pop_front();
            if (td[14:0] !== e.steer) begin
                $display("%0t: steer_angle expected %0d actual %0d", $time,
                         e.steer, $signed(td[14:0]));
                errors++;
            end
            if (tu[0] !== e.few) begin
                $display("%0t: too_few_points expected %0d actual %0d", $time,
                         e.few, tu[0]);
                errors++;
            end
            if (tu[1] !== e.dropped) begin
                $display("%0t: points_dropped expected %0d actual %0d", $time,
                         e.dropped, tu[1]);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // point_x, point_y, ego_x, ego_y, ego_heading
    logic [143:0] s_axis_tdata;
    // action
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // steer_angle, zero pad
    logic [15:0]  m_axis_tdata;
    // too_few_points, points_dropped
    logic [1:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    steer_scoreboard sb;
    bit steady;
    bit hold_req;
    int n_req;
    int n_query;
    int quiet;

    pure_pursuit_steering uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // monitor both streams at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tuser, s_axis_tdata);
                n_req++;
                if (s_axis_tuser == ACT_QUERY) n_query++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure, with one long hold-off
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                m_axis_tready <= 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // offer one request, sometimes after a random gap
    task automatic send(logic [1:0] act, logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] ex, logic signed [31:0] ey,
                        logic signed [15:0] hd);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {hd, ey, ex, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic add_point(logic signed [31:0] x, logic signed [31:0] y);
        send(ACT_APPEND, x, y, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic ask(logic signed [31:0] ex, logic signed [31:0] ey,
                       logic signed [15:0] hd);
        send(ACT_QUERY, $urandom, $urandom, ex, ey, hd);
    endtask

    // drain the block before touching its registers
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(bit idx, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= (idx == REG_LOOKAHEAD) ? ADDR_LA : ADDR_WB;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        sb.set_reg(idx, v);
    endtask

    // heading mostly in range, sometimes any 16-bit value
    function automatic logic signed [15:0] pick_heading();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    // clear, lay a random-walk path, then query near it
    task automatic path_run(int npts, int nq);
        logic signed [31:0] x, y;
        int sz;
        sz = ($urandom_range(0, 3) == 0) ? 2000000000 : 2000000;
        x = $signed($urandom_range(0, 2 * sz)) - sz;
        y = $signed($urandom_range(0, 2 * sz)) - sz;
        send(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
        for (int i = 0; i < npts; i++) begin
            add_point(x, y);
            x = x + $signed($urandom_range(0, 262144)) - 131072 + 65536;
            y = y + $signed($urandom_range(0, 262144)) - 131072;
        end
        for (int i = 0; i < nq; i++)
            ask(x - $signed($urandom_range(0, 600000)),
                y + $signed($urandom_range(0, 400000)) - 200000, pick_heading());
    endtask

    initial begin
        sb = new();
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_APPEND;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        steady = 0;
        hold_req = 0;
        n_req = 0;
        n_query = 0;
        quiet = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: too few points, growing path, zero vector, heading limits
        ask(0, 0, 0);
        add_point(0, 0);
        add_point(32'sd65536, 0);
        ask(0, 0, 0);
        add_point(32'sd131072, 32'sd65536);
        ask(0, 0, 0);
        ask(32'sd131072, 32'sd65536, 0);
        ask(-32'sd65536, 32'sd20000, 16'sd25736);
        ask(-32'sd65536, -32'sd20000, -16'sd25736);
        ask(32'sd10, 32'sd10, 16'sd32767);
        ask(32'sd10, 32'sd10, -16'sd32768);
        send(2'd3, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
        send(ACT_CLEAR, 0, 0, 0, 0, 0);
        ask(0, 0, 0);
        add_point(32'h7fffffff, 32'h7fffffff);
        add_point(32'h80000000, 32'h80000000);
        add_point(32'h7fffffff, 32'h80000000);
        ask(0, 0, 0);
        ask(32'h80000000, 32'h7fffffff, 16'sd25736);
        ask(32'h7fffffff, 32'h80000000, 0);
        settle();

        // register extremes
        reg_write(REG_LOOKAHEAD, 0);
        reg_write(REG_WHEEL_BASE, 655360);
        path_run(6, 2);
        settle();
        reg_write(REG_LOOKAHEAD, 6553600);
        reg_write(REG_WHEEL_BASE, 0);
        path_run(6, 2);
        settle();
        reg_write(REG_WHEEL_BASE, 655360);

        // full store with dropped appends
        path_run(258, 2);

        // receiver holds off while queries keep coming
        send(ACT_CLEAR, 0, 0, 0, 0, 0);
        add_point(0, 0);
        add_point(32'sd65536, 0);
        add_point(32'sd131072, 0);
        hold_req = 1;
        repeat (6) ask($urandom_range(0, 100000), $urandom_range(0, 100000), pick_heading());

        // random part
        while (n_req < 580) begin
            steady = (n_req > 380 && n_req < 460);
            if ($urandom_range(0, 9) == 0) begin
                settle();
                reg_write(REG_LOOKAHEAD, $urandom_range(0, 6553600));
                reg_write(REG_WHEEL_BASE, $urandom_range(0, 655360));
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                         16'($urandom));
            end else begin
                path_run($urandom_range(0, 4) == 0 ? $urandom_range(0, 3)
                                                   : $urandom_range(3, 14),
                         $urandom_range(1, 3));
            end
        end
        steady = 0;
        settle();

        $display("%0d requests sent, %0d queries, %0d results checked",
                 n_req, n_query, sb.matched);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
